// File: src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared package
// Number format, word types, branch codes and saturation for the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int ELEMENT_WIDTH = 16;
  localparam int FRAC_BITS     = ELEMENT_WIDTH - 2;
  localparam int SUM_WIDTH     = ELEMENT_WIDTH + 3;
  localparam int ARG_WIDTH     = ELEMENT_WIDTH + 2;
  localparam int RAD_WIDTH     = ARG_WIDTH + FRAC_BITS;
  localparam int ROOT_WIDTH    = (RAD_WIDTH + 1) / 2;
  localparam int MAG_WIDTH     = ELEMENT_WIDTH + 1;
  localparam int NUM_WIDTH     = MAG_WIDTH + FRAC_BITS + 1;
  localparam int LANES         = 3;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;

  localparam elem_t ELEM_MAX = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};
  localparam logic [NUM_WIDTH-1:0] NUM_POS_LIM =
    NUM_WIDTH'((64'd1 << (ELEMENT_WIDTH-1)) - 64'd1);
  localparam logic [NUM_WIDTH-1:0] NUM_NEG_LIM =
    NUM_WIDTH'(64'd1 << (ELEMENT_WIDTH-1));

  typedef struct packed {
    elem_t row1_col1;
    elem_t row1_col2;
    elem_t row1_col3;
    elem_t row2_col1;
    elem_t row2_col2;
    elem_t row2_col3;
    elem_t row3_col1;
    elem_t row3_col2;
    elem_t row3_col3;
  } in_word_t;

  typedef struct packed {
    elem_t quat_x;
    elem_t quat_y;
    elem_t quat_z;
    elem_t quat_w;
    logic  degenerate;
  } out_word_t;

  typedef enum logic [1:0] {
    BR_W = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } branch_t;

  typedef struct packed {
    logic             degen;
    branch_t          branch;
    logic [LANES-1:0] neg;
  } ctl_t;

  typedef logic [LANES-1:0][MAG_WIDTH-1:0] mag_t;
  typedef logic [LANES-1:0][NUM_WIDTH-1:0] quo_t;

  function automatic elem_t sat_quo(input logic neg, input logic [NUM_WIDTH-1:0] q);
    logic [NUM_WIDTH-1:0] nq;
    elem_t                res;
    nq = -q;
    if (!neg) begin
      res = (q > NUM_POS_LIM) ? ELEM_MAX : elem_t'(q[ELEMENT_WIDTH-1:0]);
    end else begin
      res = (q > NUM_NEG_LIM) ? ELEM_MIN : elem_t'(nq[ELEMENT_WIDTH-1:0]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: square-root pipeline
// Digit-by-digit integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_vld,
  input  wire rmq_pkg::ctl_t                     in_ctl,
  input  wire logic [rmq_pkg::ARG_WIDTH-1:0]     in_arg,
  input  wire rmq_pkg::mag_t                     in_mag,
  output logic                                   out_vld,
  output rmq_pkg::ctl_t                          out_ctl,
  output logic [rmq_pkg::ROOT_WIDTH-1:0]         out_root,
  output rmq_pkg::mag_t                          out_mag
);

  localparam int RW  = rmq_pkg::ROOT_WIDTH;
  localparam int NS  = 2 * RW;
  localparam int RMW = RW + 2;

  logic [RW:0]         vld_r;
  rmq_pkg::ctl_t       ctl_r  [RW+1];
  logic [RMW-1:0]      rem_r  [RW+1];
  logic [RW-1:0]       root_r [RW+1];
  logic [NS-1:0]       rad_r  [RW+1];
  rmq_pkg::mag_t       mag_r  [RW+1];

  assign vld_r[0]  = in_vld;
  assign ctl_r[0]  = in_ctl;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign rad_r[0]  = NS'({in_arg, {rmq_pkg::FRAC_BITS{1'b0}}});
  assign mag_r[0]  = in_mag;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RMW-1:0] remx;
    logic [RMW-1:0] trial;
    logic           take;
    logic [RMW-1:0] rem_nxt;
    logic [RW-1:0]  root_nxt;

    assign remx     = {rem_r[i][RMW-3:0], rad_r[i][NS-1 -: 2]};
    assign trial    = {root_r[i], 2'b01};
    assign take     = (remx >= trial);
    assign rem_nxt  = take ? (remx - trial) : remx;
    assign root_nxt = {root_r[i][RW-2:0], take};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      ctl_r[i+1]  <= ctl_r[i];
      rem_r[i+1]  <= rem_nxt;
      root_r[i+1] <= root_nxt;
      rad_r[i+1]  <= rad_r[i] << 2;
      mag_r[i+1]  <= mag_r[i];
    end
  end

  assign out_vld  = vld_r[RW];
  assign out_ctl  = ctl_r[RW];
  assign out_root = root_r[RW];
  assign out_mag  = mag_r[RW];

endmodule

`default_nettype wire

// File: src/rmq_div.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: divider pipeline
// Three restoring dividers side by side, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire rmq_pkg::ctl_t                 in_ctl,
  input  wire logic [rmq_pkg::ROOT_WIDTH-1:0] in_root,
  input  wire rmq_pkg::mag_t                 in_mag,
  output logic                               out_vld,
  output rmq_pkg::ctl_t                      out_ctl,
  output logic [rmq_pkg::ROOT_WIDTH-1:0]     out_root,
  output rmq_pkg::quo_t                      out_quo
);

  localparam int RW = rmq_pkg::ROOT_WIDTH;
  localparam int QW = rmq_pkg::NUM_WIDTH;
  localparam int NL = rmq_pkg::LANES;

  logic [QW:0]               vld_r;
  rmq_pkg::ctl_t             ctl_r  [QW+1];
  logic [RW-1:0]             root_r [QW+1];
  rmq_pkg::quo_t             num_r  [QW+1];
  logic [NL-1:0][RW:0]       rem_r  [QW+1];
  rmq_pkg::quo_t             num_nxt;

  for (genvar j = 0; j < NL; j++) begin : g_entry
    assign num_nxt[j] = QW'({in_mag[j], {rmq_pkg::FRAC_BITS{1'b0}}}) + QW'(in_root);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r[0]  <= in_ctl;
    root_r[0] <= in_root;
    num_r[0]  <= num_nxt;
  end

  assign rem_r[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [NL-1:0][RW:0]   rem_nxt;
    rmq_pkg::quo_t         quo_nxt;
    logic [RW+1:0]         dv;

    assign dv = {1'b0, root_r[i], 1'b0};

    for (genvar j = 0; j < NL; j++) begin : g_lane
      logic [RW+1:0] remx;
      logic [RW+1:0] diff;
      logic          take;

      assign remx       = {rem_r[i][j], num_r[i][j][QW-1]};
      assign take       = (remx >= dv);
      assign diff       = take ? (remx - dv) : remx;
      assign rem_nxt[j] = diff[RW:0];
      assign quo_nxt[j] = {num_r[i][j][QW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      ctl_r[i+1]  <= ctl_r[i];
      root_r[i+1] <= root_r[i];
      num_r[i+1]  <= quo_nxt;
      rem_r[i+1]  <= rem_nxt;
    end
  end

  assign out_vld  = vld_r[QW];
  assign out_ctl  = ctl_r[QW];
  assign out_root = root_r[QW];
  assign out_quo  = num_r[QW];

endmodule

`default_nettype wire

// File: src/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion
// Fixed-point 3x3 rotation matrix in, quaternion out, fully pipelined.
//
//   port group   dir  handshake         word
//   in_          in   start / busy      in_word  (nine Q2.14 elements)
//   out_         out  out_strobe        out_word (x, y, z, w, degenerate)
//
// One word enters per cycle; busy stays low. Each word passes an input
// register, the bit-per-stage square root, a divider entry register, the
// bit-per-stage dividers and an output register. Reset clears only the
// valid bits. Results show for one cycle on out_strobe and are not held.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire rmq_pkg::in_word_t  in_word,
  output logic                    out_strobe,
  output rmq_pkg::out_word_t      out_word
);

  localparam int SW  = rmq_pkg::SUM_WIDTH;
  localparam int AW  = rmq_pkg::ARG_WIDTH;
  localparam int RW  = rmq_pkg::ROOT_WIDTH;
  localparam int QW  = rmq_pkg::NUM_WIDTH;
  localparam int MW  = rmq_pkg::MAG_WIDTH;
  localparam int LAT = RW + QW + 3;
  localparam logic signed [SW-1:0] ONE = SW'(64'd1 << rmq_pkg::FRAC_BITS);

  logic signed [SW-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
  logic signed [SW-1:0] trace, arg_sel;
  logic signed [SW-1:0] d_a, d_b, d_c;
  logic signed [SW-1:0] s_ab, s_ac, s_bc;
  logic signed [SW-1:0] lane_d [rmq_pkg::LANES];

  logic                        s0_vld_r;
  rmq_pkg::ctl_t               s0_ctl_r, s0_ctl_nxt;
  logic [AW-1:0]               s0_arg_r, s0_arg_nxt;
  rmq_pkg::mag_t               s0_mag_r, s0_mag_nxt;

  logic                        sq_vld;
  rmq_pkg::ctl_t               sq_ctl;
  logic [RW-1:0]               sq_root;
  rmq_pkg::mag_t               sq_mag;

  logic                        dv_vld;
  rmq_pkg::ctl_t               dv_ctl;
  logic [RW-1:0]               dv_root;
  rmq_pkg::quo_t               dv_quo;

  logic [RW:0]                 prim_sum;
  rmq_pkg::elem_t              prim;
  rmq_pkg::elem_t              lane_q [rmq_pkg::LANES];
  logic                        out_strobe_r;
  rmq_pkg::out_word_t          out_word_r, out_word_nxt;

  assign busy = 1'b0;

  assign m11 = SW'(in_word.row1_col1);
  assign m12 = SW'(in_word.row1_col2);
  assign m13 = SW'(in_word.row1_col3);
  assign m21 = SW'(in_word.row2_col1);
  assign m22 = SW'(in_word.row2_col2);
  assign m23 = SW'(in_word.row2_col3);
  assign m31 = SW'(in_word.row3_col1);
  assign m32 = SW'(in_word.row3_col2);
  assign m33 = SW'(in_word.row3_col3);

  assign trace = m11 + m22 + m33;
  assign d_a   = m32 - m23;
  assign d_b   = m13 - m31;
  assign d_c   = m21 - m12;
  assign s_ab  = m12 + m21;
  assign s_ac  = m13 + m31;
  assign s_bc  = m23 + m32;

  always_comb begin
    if (trace > 0) begin
      s0_ctl_nxt.branch = rmq_pkg::BR_W;
      arg_sel           = ONE + trace;
      lane_d[0]         = d_a;
      lane_d[1]         = d_b;
      lane_d[2]         = d_c;
    end else if (m11 > m22 && m11 > m33) begin
      s0_ctl_nxt.branch = rmq_pkg::BR_X;
      arg_sel           = ONE + m11 - m22 - m33;
      lane_d[0]         = d_a;
      lane_d[1]         = s_ab;
      lane_d[2]         = s_ac;
    end else if (m22 > m33) begin
      s0_ctl_nxt.branch = rmq_pkg::BR_Y;
      arg_sel           = ONE + m22 - m11 - m33;
      lane_d[0]         = d_b;
      lane_d[1]         = s_ab;
      lane_d[2]         = s_bc;
    end else begin
      s0_ctl_nxt.branch = rmq_pkg::BR_Z;
      arg_sel           = ONE + m33 - m11 - m22;
      lane_d[0]         = d_c;
      lane_d[1]         = s_ac;
      lane_d[2]         = s_bc;
    end
    s0_ctl_nxt.degen = (arg_sel <= 0);
    s0_arg_nxt       = s0_ctl_nxt.degen ? '0 : arg_sel[AW-1:0];
    for (int j = 0; j < rmq_pkg::LANES; j++) begin
      s0_ctl_nxt.neg[j] = lane_d[j][SW-1];
      s0_mag_nxt[j]     = lane_d[j][SW-1] ? MW'(-lane_d[j]) : MW'(lane_d[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_ctl_r <= s0_ctl_nxt;
    s0_arg_r <= s0_arg_nxt;
    s0_mag_r <= s0_mag_nxt;
  end

  rmq_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s0_vld_r),
    .in_ctl   (s0_ctl_r),
    .in_arg   (s0_arg_r),
    .in_mag   (s0_mag_r),
    .out_vld  (sq_vld),
    .out_ctl  (sq_ctl),
    .out_root (sq_root),
    .out_mag  (sq_mag)
  );

  rmq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_vld),
    .in_ctl   (sq_ctl),
    .in_root  (sq_root),
    .in_mag   (sq_mag),
    .out_vld  (dv_vld),
    .out_ctl  (dv_ctl),
    .out_root (dv_root),
    .out_quo  (dv_quo)
  );

  assign prim_sum = {1'b0, dv_root} + (RW+1)'(1);
  assign prim     = rmq_pkg::sat_quo(1'b0, QW'(prim_sum[RW:1]));

  for (genvar j = 0; j < rmq_pkg::LANES; j++) begin : g_sat
    assign lane_q[j] = rmq_pkg::sat_quo(dv_ctl.neg[j], dv_quo[j]);
  end

  always_comb begin
    out_word_nxt = '0;
    unique case (dv_ctl.branch)
      rmq_pkg::BR_W: begin
        out_word_nxt.quat_w = prim;
        out_word_nxt.quat_x = lane_q[0];
        out_word_nxt.quat_y = lane_q[1];
        out_word_nxt.quat_z = lane_q[2];
      end
      rmq_pkg::BR_X: begin
        out_word_nxt.quat_x = prim;
        out_word_nxt.quat_w = lane_q[0];
        out_word_nxt.quat_y = lane_q[1];
        out_word_nxt.quat_z = lane_q[2];
      end
      rmq_pkg::BR_Y: begin
        out_word_nxt.quat_y = prim;
        out_word_nxt.quat_w = lane_q[0];
        out_word_nxt.quat_x = lane_q[1];
        out_word_nxt.quat_z = lane_q[2];
      end
      default: begin
        out_word_nxt.quat_z = prim;
        out_word_nxt.quat_w = lane_q[0];
        out_word_nxt.quat_x = lane_q[1];
        out_word_nxt.quat_y = lane_q[2];
      end
    endcase
    if (dv_ctl.degen) begin
      out_word_nxt            = '0;
      out_word_nxt.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result without matching input word");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.degenerate) |->
      (out_word.quat_x == '0 && out_word.quat_y == '0 &&
       out_word.quat_z == '0 && out_word.quat_w == '0))
    else $error("degenerate result with nonzero components");

endmodule

`default_nettype wire

// File: dv/rotation_matrix_to_quaternion_tb.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: testbench
// Drives directed and random matrices through start/busy, predicts each
// quaternion in fixed point and compares every strobed result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE_Q     = 1 << rmq_pkg::FRAC_BITS;
  localparam int LATENCY   = rmq_pkg::ROOT_WIDTH + rmq_pkg::NUM_WIDTH + 3;
  localparam int MAX_CYCLE = 200000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  rmq_pkg::in_word_t  in_word;
  logic               out_strobe;
  rmq_pkg::out_word_t out_word;

  rmq_pkg::in_word_t  pending_mats[$];
  rmq_pkg::out_word_t expected_quats[$];
  int                 cycle_count;
  int                 fail_count;
  bit                 stim_done;
  bit                 steady;

  rotation_matrix_to_quaternion uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_strobe(out_strobe), .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic rmq_pkg::elem_t clamp(input longint v);
    if (v > longint'(rmq_pkg::ELEM_MAX)) return rmq_pkg::ELEM_MAX;
    if (v < longint'(rmq_pkg::ELEM_MIN)) return rmq_pkg::ELEM_MIN;
    return rmq_pkg::elem_t'(v);
  endfunction

  function automatic rmq_pkg::elem_t half_ratio(input longint d,
                                                input longint unsigned r);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? longint'(-d) : d;
    q = ((mag << rmq_pkg::FRAC_BITS) + r) / (r << 1);
    return clamp((d < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic rmq_pkg::out_word_t quat_of(input rmq_pkg::in_word_t m);
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33, tr, arg;
    longint unsigned r;
    rmq_pkg::elem_t prim;
    rmq_pkg::branch_t br;
    rmq_pkg::out_word_t q;
    a11 = m.row1_col1; a12 = m.row1_col2; a13 = m.row1_col3;
    a21 = m.row2_col1; a22 = m.row2_col2; a23 = m.row2_col3;
    a31 = m.row3_col1; a32 = m.row3_col2; a33 = m.row3_col3;
    q = '0;
    tr = a11 + a22 + a33;
    if (tr > 0) begin
      br = rmq_pkg::BR_W; arg = ONE_Q + tr;
    end else if (a11 > a22 && a11 > a33) begin
      br = rmq_pkg::BR_X; arg = ONE_Q + a11 - a22 - a33;
    end else if (a22 > a33) begin
      br = rmq_pkg::BR_Y; arg = ONE_Q + a22 - a11 - a33;
    end else begin
      br = rmq_pkg::BR_Z; arg = ONE_Q + a33 - a11 - a22;
    end
    if (arg <= 0) begin
      q.degenerate = 1'b1;
      return q;
    end
    r = int_sqrt(longint'(arg) << rmq_pkg::FRAC_BITS);
    prim = clamp(longint'((r + 1) >> 1));
    case (br)
      rmq_pkg::BR_W: begin
        q.quat_w = prim;
        q.quat_x = half_ratio(a32 - a23, r);
        q.quat_y = half_ratio(a13 - a31, r);
        q.quat_z = half_ratio(a21 - a12, r);
      end
      rmq_pkg::BR_X: begin
        q.quat_x = prim;
        q.quat_w = half_ratio(a32 - a23, r);
        q.quat_y = half_ratio(a12 + a21, r);
        q.quat_z = half_ratio(a13 + a31, r);
      end
      rmq_pkg::BR_Y: begin
        q.quat_y = prim;
        q.quat_w = half_ratio(a13 - a31, r);
        q.quat_x = half_ratio(a12 + a21, r);
        q.quat_z = half_ratio(a23 + a32, r);
      end
      default: begin
        q.quat_z = prim;
        q.quat_w = half_ratio(a21 - a12, r);
        q.quat_x = half_ratio(a13 + a31, r);
        q.quat_y = half_ratio(a23 + a32, r);
      end
    endcase
    return q;
  endfunction

  function automatic rmq_pkg::in_word_t diag_mat(input int d1, input int d2,
                                                 input int d3, input int off);
    rmq_pkg::in_word_t m;
    m = '0;
    m.row1_col1 = rmq_pkg::elem_t'(d1);
    m.row2_col2 = rmq_pkg::elem_t'(d2);
    m.row3_col3 = rmq_pkg::elem_t'(d3);
    m.row1_col2 = rmq_pkg::elem_t'(off); m.row2_col1 = rmq_pkg::elem_t'(-off);
    m.row1_col3 = rmq_pkg::elem_t'(off / 2); m.row3_col1 = rmq_pkg::elem_t'(off / 3);
    m.row2_col3 = rmq_pkg::elem_t'(-off / 4); m.row3_col2 = rmq_pkg::elem_t'(off / 5);
    return m;
  endfunction

  function automatic rmq_pkg::elem_t near(input int base);
    return clamp(longint'(base) + $urandom_range(0, 600) - 300);
  endfunction

  function automatic rmq_pkg::in_word_t random_mat();
    rmq_pkg::in_word_t m;
    int kind;
    kind = $urandom_range(0, 9);
    m = rmq_pkg::in_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if (kind < 6) begin
      // near-rotation: signed diagonal with small mixing (half the kinds widen three off-diagonals to +/-1.0)
      m.row1_col2 = near(0); m.row1_col3 = near(0); m.row2_col1 = near(0);
      m.row2_col3 = near(0); m.row3_col1 = near(0); m.row3_col2 = near(0);
      m.row1_col1 = near($urandom_range(0, 1) ? ONE_Q : -ONE_Q);
      m.row2_col2 = near($urandom_range(0, 1) ? ONE_Q : -ONE_Q);
      m.row3_col3 = near($urandom_range(0, 1) ? ONE_Q : -ONE_Q);
      if (kind >= 3) begin
        m.row1_col2 = rmq_pkg::elem_t'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
        m.row2_col1 = rmq_pkg::elem_t'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
        m.row2_col3 = rmq_pkg::elem_t'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
      end
    end else if (kind < 8) begin
      m.row1_col1 = rmq_pkg::elem_t'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
      m.row2_col2 = rmq_pkg::elem_t'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
      m.row3_col3 = rmq_pkg::elem_t'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
    end
    return m;
  endfunction

  initial begin
    rmq_pkg::in_word_t m;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    stim_done = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    steady = 1'b0;
    pending_mats.push_back(diag_mat(ONE_Q, ONE_Q, ONE_Q, 0));
    pending_mats.push_back(diag_mat(ONE_Q, -ONE_Q, -ONE_Q, 100));
    pending_mats.push_back(diag_mat(-ONE_Q, ONE_Q, -ONE_Q, 100));
    pending_mats.push_back(diag_mat(-ONE_Q, -ONE_Q, ONE_Q, -100));
    pending_mats.push_back(diag_mat(0, 0, 0, 5000));
    pending_mats.push_back(diag_mat(-100, -100, -100, 0));
    pending_mats.push_back(diag_mat(-ONE_Q, -ONE_Q, -ONE_Q, 0));
    pending_mats.push_back(diag_mat(-20000, -20000, -20000, 0));
    pending_mats.push_back(diag_mat(-32768, -32768, -32768, 0));
    pending_mats.push_back(diag_mat(32767, 32767, 32767, 32767));
    pending_mats.push_back(diag_mat(-200, -200, -200, 32767));
    pending_mats.push_back(diag_mat(-10000, -10000, 0, -32768));
    pending_mats.push_back(diag_mat(-5000, -5000, -5000, -32768));
    pending_mats.push_back(diag_mat(1, 0, -1, 0));
    pending_mats.push_back(diag_mat(0, 0, -1, 7));
    pending_mats.push_back(diag_mat(-1, 0, 0, 7));
    pending_mats.push_back(diag_mat(ONE_Q, ONE_Q, -ONE_Q, 77));
    pending_mats.push_back(diag_mat(-ONE_Q, -ONE_Q, ONE_Q, -9));
    pending_mats.push_back(rmq_pkg::in_word_t'({9{16'h8000}}));
    pending_mats.push_back(rmq_pkg::in_word_t'({9{16'h7fff}}));
    pending_mats.push_back(rmq_pkg::in_word_t'({9{16'hffff}}));
    pending_mats.push_back(rmq_pkg::in_word_t'({9{16'h0000}}));
    repeat (700) begin
      m = random_mat();
      pending_mats.push_back(m);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == 300) steady <= 1'b1;
    if (cycle_count == 500) steady <= 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_quats.push_back(quat_of(in_word));
      void'(pending_mats.pop_front());
      if (pending_mats.size() != 0 && (steady || $urandom_range(0, 99) >= 22)) begin
        in_word <= pending_mats[0];
      end else begin
        start <= 1'b0;
        if (pending_mats.size() == 0) stim_done <= 1'b1;
      end
    end else if (!start && pending_mats.size() != 0
                 && (steady || $urandom_range(0, 99) >= 22)) begin
      start <= 1'b1;
      in_word <= pending_mats[0];
    end
  end

  always @(posedge clk) begin
    rmq_pkg::out_word_t exp_q;
    if (rst_n && out_strobe) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_word);
        fail_count++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (out_word !== exp_q) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h w=%h dg=%b",
                   $time, exp_q.quat_x, exp_q.quat_y, exp_q.quat_z, exp_q.quat_w,
                   exp_q.degenerate);
          $display("%0t:          actual   x=%h y=%h z=%h w=%h dg=%b",
                   $time, out_word.quat_x, out_word.quat_y, out_word.quat_z,
                   out_word.quat_w, out_word.degenerate);
          fail_count++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_quats.size() != 0 && cycle_count < MAX_CYCLE) @(posedge clk);
    if (cycle_count >= MAX_CYCLE) begin
      $display("[FAIL] regression broken");
    end else begin
      repeat (LATENCY + 10) @(posedge clk);
      if (fail_count == 0 && expected_quats.size() == 0) begin
        $display("[ OK ] regression clean");
      end else begin
        $display("[FAIL] regression broken");
      end
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= MAX_CYCLE);
    if (!stim_done) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

`default_nettype wire
